/* hdl/preintegrated_transfer_table_core_defines.svh */
// Shared assertion macros.
`ifndef PREINTEGRATED_TRANSFER_TABLE_CORE_DEFINES_SVH
`define PREINTEGRATED_TRANSFER_TABLE_CORE_DEFINES_SVH

// Same-cycle implication.
`define PTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ptt_pkg.sv */
package ptt_pkg;
    localparam int unsigned ENTRY_COUNT = 256;
    localparam int unsigned IDX_W       = 8;
    localparam int unsigned CSUM_W      = 40;
    localparam int unsigned ASUM_W      = 26;
    localparam int unsigned DIVD_W      = 41;
    localparam int unsigned DEN_W       = 19;
    localparam int unsigned QUOT_W      = 16;
    localparam int unsigned COLOR_DEN_K = 6 * 255;
    localparam int unsigned TSIZE_RESET = 256;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic [CSUM_W-1:0] sum_red;
        logic [CSUM_W-1:0] sum_green;
        logic [CSUM_W-1:0] sum_blue;
        logic [ASUM_W-1:0] sum_opac;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [15:0]       opac;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_entry           wdata;
    } t_mem_req;
endpackage

/* hdl/ptt_mem.sv */
module ptt_mem (
    input  logic              i_clk,
    input  ptt_pkg::t_mem_req i_req,
    output ptt_pkg::t_entry   o_rdata
);
    import ptt_pkg::*;

    t_entry r_mem [ENTRY_COUNT];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/ptt_div.sv */
// Restoring divider, one quotient bit per cycle, saturating to 16 bits.
module ptt_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [ptt_pkg::DIVD_W-1:0]   i_dividend,
    input  logic        [ptt_pkg::DEN_W-1:0]    i_den,
    output logic                                o_done,
    output logic        [ptt_pkg::QUOT_W-1:0]   o_quot
);
    import ptt_pkg::*;

    localparam int unsigned CNT_W = $clog2(QUOT_W);

    logic [DIVD_W-2:0]  r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [QUOT_W-1:0]  r_q;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_sat;
    logic               r_done;
    logic [DIVD_W-2:0]  shifted;
    logic [DIVD_W-1:0]  sat_lim;

    assign shifted = (DIVD_W-1)'(r_den) << r_cnt;
    assign sat_lim = DIVD_W'(i_den) << QUOT_W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUOT_W - 1);
                r_q    <= '0;
                r_den  <= i_den;
                if (i_dividend < 0) begin
                    r_rem <= '0;
                    r_sat <= 1'b0;
                end else begin
                    r_rem <= i_dividend[DIVD_W-2:0];
                    r_sat <= $unsigned(i_dividend) >= sat_lim;
                end
            end else if (r_busy) begin
                if (r_rem >= shifted) begin
                    r_rem        <= r_rem - shifted;
                    r_q[r_cnt]   <= 1'b1;
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? '1 : r_q;
endmodule

/* hdl/preintegrated_transfer_table_core.sv */
// Load beat: ignored if past the table; for index zero only the write; otherwise read, 3 channel steps, write.
// Query beat: two table reads, setup, 16-step divider, result; straight to the result on index error.
// One beat is in work at a time; the result register lets the next beat enter while it waits.
// Reset (synchronous, active low) clears control and sets table_size to 256; table
// contents are undefined until loaded.
module preintegrated_transfer_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_entry_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [15:0] i_opacity,
    input  logic [7:0]  i_front_index,
    input  logic [7:0]  i_back_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_out_red,
    output logic [15:0] o_out_green,
    output logic [15:0] o_out_blue,
    output logic [15:0] o_out_opacity,
    output logic        o_index_error
);
    import ptt_pkg::*;
    `include "preintegrated_transfer_table_core_defines.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_LD_RD, S_LD_CH, S_LD_WR,
        S_Q_RDF, S_Q_RDB, S_Q_SET, S_Q_DIV, S_DONE
    } t_state;

    t_state          r_state;
    logic [8:0]      r_tsize;
    logic [7:0]      r_idx, r_front, r_back;
    logic [7:0]      r_red, r_green, r_blue;
    logic [15:0]     r_opac;
    logic [1:0]      r_ch;
    logic            r_first;
    logic            r_err;
    logic [CSUM_W-1:0] r_sum [3];
    t_entry          r_ef;
    logic            r_out_valid;
    logic [15:0]     r_o_red, r_o_green, r_o_blue, r_o_opac;
    logic            r_o_err;

    t_mem_req        mem_req;
    t_entry          rdata;
    logic            in_take, out_take, out_free;
    logic            res_load;
    logic            div_start;
    logic signed [DIVD_W-1:0] div_dvd [4];
    logic [DEN_W-1:0] div_den [4];
    logic [3:0]      div_done;
    logic [15:0]     div_q [4];

    // per-channel trapezoid term
    logic [7:0]      c1, c0;
    logic [16:0]     a_sum;
    logic [8:0]      c_sum;
    logic [CSUM_W-1:0] term;
    logic [CSUM_W-1:0] prev_sum;
    logic [ASUM_W-1:0] new_asum;

    // query setup
    logic            neg;
    logic [7:0]      span;
    logic [CSUM_W-1:0] sb [3];
    logic [CSUM_W-1:0] sf [3];
    logic [7:0]      cf [3];
    logic [DIVD_W-1:0] cdiff [3];
    logic [DIVD_W-1:0] adiff;

    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign res_load   = (r_state == S_DONE) && out_free;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        unique case (r_ch)
            2'd0:    begin c1 = r_red;   c0 = rdata.red;   prev_sum = rdata.sum_red;   end
            2'd1:    begin c1 = r_green; c0 = rdata.green; prev_sum = rdata.sum_green; end
            default: begin c1 = r_blue;  c0 = rdata.blue;  prev_sum = rdata.sum_blue;  end
        endcase
        a_sum = 17'(r_opac) + 17'(rdata.opac);
        c_sum = 9'(c1) + 9'(c0);
        term  = CSUM_W'(a_sum * c_sum) + CSUM_W'(r_opac * c1) + CSUM_W'(rdata.opac * c0);
        new_asum = rdata.sum_opac + ASUM_W'(r_opac) + ASUM_W'(rdata.opac);
    end

    // memory port: write at the load index, read at the current lookup address
    always_comb begin
        mem_req.we    = (r_state == S_LD_WR);
        mem_req.wdata.sum_red   = r_first ? '0 : r_sum[0];
        mem_req.wdata.sum_green = r_first ? '0 : r_sum[1];
        mem_req.wdata.sum_blue  = r_first ? '0 : r_sum[2];
        mem_req.wdata.sum_opac  = r_first ? '0 : new_asum;
        mem_req.wdata.red   = r_red;
        mem_req.wdata.green = r_green;
        mem_req.wdata.blue  = r_blue;
        mem_req.wdata.opac  = r_opac;
        unique case (r_state)
            S_LD_RD, S_LD_CH: mem_req.addr = r_idx - 8'd1;
            S_Q_RDF:          mem_req.addr = r_front;
            S_Q_RDB:          mem_req.addr = r_back;
            default:          mem_req.addr = r_idx;
        endcase
    end

    ptt_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    // r_ef holds the front entry, rdata the back entry during S_Q_SET
    always_comb begin
        neg  = r_back < r_front;
        span = neg ? (r_front - r_back) : (r_back - r_front);
        sb[0] = rdata.sum_red;  sb[1] = rdata.sum_green;  sb[2] = rdata.sum_blue;
        sf[0] = r_ef.sum_red;   sf[1] = r_ef.sum_green;   sf[2] = r_ef.sum_blue;
        cf[0] = r_ef.red;       cf[1] = r_ef.green;       cf[2] = r_ef.blue;
        for (int i = 0; i < 3; i++) begin
            cdiff[i] = neg ? (DIVD_W'(sf[i]) - DIVD_W'(sb[i]))
                           : (DIVD_W'(sb[i]) - DIVD_W'(sf[i]));
        end
        adiff = neg ? (DIVD_W'(r_ef.sum_opac) - DIVD_W'(rdata.sum_opac))
                    : (DIVD_W'(rdata.sum_opac) - DIVD_W'(r_ef.sum_opac));
        for (int i = 0; i < 3; i++) begin
            if (span == '0) begin
                div_dvd[i] = $signed(DIVD_W'(r_ef.opac * cf[i]));
                div_den[i] = DEN_W'(255);
            end else begin
                div_dvd[i] = $signed(cdiff[i]);
                div_den[i] = DEN_W'(span) * DEN_W'(COLOR_DEN_K);
            end
        end
        if (span == '0) begin
            div_dvd[3] = $signed(DIVD_W'(r_ef.opac));
            div_den[3] = DEN_W'(1);
        end else begin
            div_dvd[3] = $signed(adiff);
            div_den[3] = DEN_W'(span) << 1;
        end
    end

    assign div_start = (r_state == S_Q_SET);

    for (genvar g = 0; g < 4; g++) begin : g_div
        ptt_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (div_start),
            .i_dividend (div_dvd[g]),
            .i_den      (div_den[g]),
            .o_done     (div_done[g]),
            .o_quot     (div_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tsize     <= 9'(TSIZE_RESET);
            r_out_valid <= 1'b0;
            r_ch        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tsize <= i_cfg_wdata;
            end
            // a new result taking the register in the same cycle keeps valid high
            if (out_take && !res_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_idx   <= i_entry_index;
                        r_red   <= i_red;
                        r_green <= i_green;
                        r_blue  <= i_blue;
                        r_opac  <= i_opacity;
                        r_front <= i_front_index;
                        r_back  <= i_back_index;
                        r_first <= (i_entry_index == '0);
                        r_ch    <= '0;
                        if (i_func == FUNC_LOAD) begin
                            if ({1'b0, i_entry_index} >= r_tsize) begin
                                r_state <= S_IDLE;
                            end else if (i_entry_index == '0) begin
                                r_state <= S_LD_WR;
                            end else begin
                                r_state <= S_LD_RD;
                            end
                        end else begin
                            r_err <= ({1'b0, i_front_index} >= r_tsize) ||
                                     ({1'b0, i_back_index} >= r_tsize);
                            if (({1'b0, i_front_index} >= r_tsize) ||
                                ({1'b0, i_back_index} >= r_tsize)) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_Q_RDF;
                            end
                        end
                    end
                end
                S_LD_RD: r_state <= S_LD_CH;
                S_LD_CH: begin
                    r_sum[r_ch] <= prev_sum + term;
                    if (r_ch == 2'd2) begin
                        r_state <= S_LD_WR;
                    end else begin
                        r_ch <= r_ch + 2'd1;
                    end
                end
                S_LD_WR: r_state <= S_IDLE;
                S_Q_RDF: r_state <= S_Q_RDB;
                S_Q_RDB: begin
                    r_ef    <= rdata;
                    r_state <= S_Q_SET;
                end
                S_Q_SET: r_state <= S_Q_DIV;
                S_Q_DIV: begin
                    if (div_done[0]) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_err     <= r_err;
                        r_o_red     <= r_err ? '0 : div_q[0];
                        r_o_green   <= r_err ? '0 : div_q[1];
                        r_o_blue    <= r_err ? '0 : div_q[2];
                        r_o_opac    <= r_err ? '0 : div_q[3];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_red     = r_o_red;
    assign o_out_green   = r_o_green;
    assign o_out_blue    = r_o_blue;
    assign o_out_opacity = r_o_opac;
    assign o_index_error = r_o_err;

    `PTT_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, r_out_valid && r_o_err, (r_o_red == '0) && (r_o_green == '0) && (r_o_blue == '0) && (r_o_opac == '0), "error beat carries data")
    `PTT_ASSERT_NOW(a_div_done_state, i_clk, i_rst_n, div_done[0], r_state == S_Q_DIV, "divider finished outside divide wait")
    `PTT_ASSERT_NEXT(a_set_starts_div, i_clk, i_rst_n, r_state == S_Q_SET, r_state == S_Q_DIV, "setup not followed by divide")
    `PTT_ASSERT_NOW(a_lanes_agree, i_clk, i_rst_n, div_done[0], div_done == 4'hF, "divider lanes out of step")
endmodule

/* tb/preintegrated_transfer_table_checker.sv */
`timescale 1ns / 1ps

module preintegrated_transfer_table_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_entry_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [15:0] i_opacity,
    input  logic [7:0]  i_front_index,
    input  logic [7:0]  i_back_index,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_out_red,
    input  logic [15:0] i_out_green,
    input  logic [15:0] i_out_blue,
    input  logic [15:0] i_out_opacity,
    input  logic        i_index_error,
    output int          o_fail_count,
    output int          o_pending
);
    import ptt_pkg::*;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] opac;
        logic        err;
    } t_segment;

    logic [7:0]  tf_color [ENTRY_COUNT][3];
    logic [15:0] tf_opac  [ENTRY_COUNT];
    logic [63:0] color_integral [ENTRY_COUNT][3];
    logic [63:0] opac_integral  [ENTRY_COUNT];
    logic [8:0]  table_size;
    t_segment    segment_q [$];

    function automatic logic [15:0] clamp_quotient(logic [63:0] hi, logic [63:0] lo,
                                                   longint den, bit neg);
        longint diff;
        longint q;
        diff = longint'(hi) - longint'(lo);
        if (neg) diff = -diff;
        q = diff / den;
        if (q < 0) return 16'd0;
        if (q > 65535) return 16'hFFFF;
        return q[15:0];
    endfunction

    function automatic t_segment integrate_segment(int f, int b, int lim);
        t_segment s;
        logic [15:0] v [3];
        longint span;
        bit neg;
        s = '0;
        if (f >= lim || b >= lim) begin
            s.err = 1'b1;
            return s;
        end
        if (f == b) begin
            for (int ch = 0; ch < 3; ch++)
                v[ch] = 16'((64'(tf_opac[f]) * 64'(tf_color[f][ch])) / 255);
            s.opac = tf_opac[f];
        end else begin
            neg  = b < f;
            span = neg ? f - b : b - f;
            for (int ch = 0; ch < 3; ch++)
                v[ch] = clamp_quotient(color_integral[b][ch], color_integral[f][ch],
                                       COLOR_DEN_K * span, neg);
            s.opac = clamp_quotient(opac_integral[b], opac_integral[f], 2 * span, neg);
        end
        s.red   = v[0];
        s.green = v[1];
        s.blue  = v[2];
        return s;
    endfunction

    always @(posedge i_clk) begin
        int lim;
        int k;
        logic [63:0] a0, a1, c0, c1;
        logic [7:0] rgb [3];
        t_segment got, want;
        if (!i_rst_n) begin
            table_size = 9'(TSIZE_RESET);
            segment_q.delete();
            o_fail_count = 0;
        end else begin
            lim = (table_size < ENTRY_COUNT) ? int'(table_size) : int'(ENTRY_COUNT);
            if (i_in_valid && !i_in_stall) begin
                if (i_func == FUNC_LOAD) begin
                    k = int'(i_entry_index);
                    if (k < lim) begin
                        rgb = '{i_red, i_green, i_blue};
                        for (int ch = 0; ch < 3; ch++) tf_color[k][ch] = rgb[ch];
                        tf_opac[k] = i_opacity;
                        if (k == 0) begin
                            for (int ch = 0; ch < 3; ch++) color_integral[0][ch] = '0;
                            opac_integral[0] = '0;
                        end else begin
                            a1 = 64'(tf_opac[k]);
                            a0 = 64'(tf_opac[k-1]);
                            for (int ch = 0; ch < 3; ch++) begin
                                c1 = 64'(tf_color[k][ch]);
                                c0 = 64'(tf_color[k-1][ch]);
                                color_integral[k][ch] = color_integral[k-1][ch]
                                    + (a1 + a0) * (c1 + c0) + a1 * c1 + a0 * c0;
                            end
                            opac_integral[k] = opac_integral[k-1] + a1 + a0;
                        end
                    end
                end else begin
                    segment_q.push_back(integrate_segment(int'(i_front_index),
                                                          int'(i_back_index), lim));
                end
            end
            if (i_cfg_we) table_size = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                got = '{i_out_red, i_out_green, i_out_blue, i_out_opacity, i_index_error};
                if (segment_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count++;
                end else begin
                    want = segment_q.pop_front();
                    if (got.red !== want.red) begin
                        $error("out_red: expected %0d, got %0d", want.red, got.red);
                        o_fail_count++;
                    end
                    if (got.green !== want.green) begin
                        $error("out_green: expected %0d, got %0d", want.green, got.green);
                        o_fail_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("out_blue: expected %0d, got %0d", want.blue, got.blue);
                        o_fail_count++;
                    end
                    if (got.opac !== want.opac) begin
                        $error("out_opacity: expected %0d, got %0d", want.opac, got.opac);
                        o_fail_count++;
                    end
                    if (got.err !== want.err) begin
                        $error("index_error: expected %0d, got %0d", want.err, got.err);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = segment_q.size();
    end
endmodule

/* tb/tb_preintegrated_transfer_table_core.sv */
`timescale 1ns / 1ps

module tb_preintegrated_transfer_table_core;
    import ptt_pkg::*;

    localparam int STALL_LIMIT = 4000;   // cycles with no beat on any channel
    localparam int DRAIN_WAIT  = 40;     // longer than a full query

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [8:0]  i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_func = FUNC_LOAD;
    logic [7:0]  i_entry_index = '0;
    logic [7:0]  i_red = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_blue = '0;
    logic [15:0] i_opacity = '0;
    logic [7:0]  i_front_index = '0;
    logic [7:0]  i_back_index = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_out_red;
    logic [15:0] o_out_green;
    logic [15:0] o_out_blue;
    logic [15:0] o_out_opacity;
    logic        o_index_error;

    int fail_count;
    int pending;
    bit calm = 1'b0;        // set to run a stretch with no bubbles or backpressure
    int quiet_cycles = 0;
    int size_now = TSIZE_RESET;
    int next_load = 0;      // loads run ascending from zero
    int built = 0;          // entries 0..built-1 have been written at least once

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    preintegrated_transfer_table_core u_top (.*);

    preintegrated_transfer_table_checker u_check (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_in_valid, .i_in_stall(o_in_stall), .i_func, .i_entry_index,
        .i_red, .i_green, .i_blue, .i_opacity, .i_front_index, .i_back_index,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out_red(o_out_red),
        .i_out_green(o_out_green), .i_out_blue(o_out_blue),
        .i_out_opacity(o_out_opacity), .i_index_error(o_index_error),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Random backpressure on the result side.
    always @(negedge i_clk)
        i_out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 32);

    // Watchdog: any beat on either channel or a register write restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("preintegrated_transfer_table_core: mismatch");
            $finish;
        end
    end

    function automatic logic [7:0] pick_color();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] pick_opacity();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Present one beat and hold it until taken. Called just after a falling edge;
    // valid stays high on exit so back-to-back beats need no reassignment.
    task automatic push_beat(logic fn, int idx, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b, logic [15:0] a, int f, int bk);
        while (!calm && $urandom_range(0, 99) < 32) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_func        <= fn;
        i_entry_index <= 8'(idx);
        i_red         <= r;
        i_green       <= g;
        i_blue        <= b;
        i_opacity     <= a;
        i_front_index <= 8'(f);
        i_back_index  <= 8'(bk);
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic load_entry(int idx, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [15:0] a);
        push_beat(FUNC_LOAD, idx, r, g, b, a, $urandom_range(0, 255), $urandom_range(0, 255));
        if (idx < size_now && idx + 1 > built) built = idx + 1;
    endtask

    task automatic load_random(int idx);
        load_entry(idx, pick_color(), pick_color(), pick_color(), pick_opacity());
    endtask

    task automatic query_pair(int f, int b);
        push_beat(FUNC_QUERY, $urandom_range(0, 255), pick_color(), pick_color(),
                  pick_color(), pick_opacity(), f, b);
    endtask

    // table_size changes only with the block drained; loads give no result, so
    // allow a load still in flight to finish too.
    task automatic write_table_size(int v);
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= 9'(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        size_now  = v;
        next_load = 0;
    endtask

    task automatic random_phase(int count);
        int lim, r, span, f, b;
        lim = (size_now < ENTRY_COUNT) ? size_now : ENTRY_COUNT;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            span = (built < lim) ? built : lim;
            if (r < 6) next_load = 0;   // start a fresh table build
            if (r < 40 || span == 0) begin
                if (next_load >= lim) next_load = 0;
                load_random(next_load);
                next_load++;
            end else if (r < 46 && lim < ENTRY_COUNT) begin
                // load beyond the table: dropped by the block
                load_random($urandom_range(lim, 255));
            end else if (r < 54 && lim < ENTRY_COUNT) begin
                // one index out of range
                if ($urandom_range(0, 1))
                    query_pair($urandom_range(lim, 255), $urandom_range(0, 255));
                else
                    query_pair($urandom_range(0, 255), $urandom_range(lim, 255));
            end else begin
                f = $urandom_range(0, span - 1);
                b = ($urandom_range(0, 99) < 15) ? f : $urandom_range(0, span - 1);
                query_pair(f, b);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: color and opacity extremes, equal / forward / reversed spans.
        load_entry(0, 8'd255, 8'd0, 8'd255, 16'hFFFF);
        load_entry(1, 8'd0, 8'd255, 8'd0, 16'd0);
        load_entry(2, 8'd255, 8'd255, 8'd255, 16'hFFFF);
        load_entry(3, 8'd1, 8'd2, 8'd3, 16'd12345);
        query_pair(0, 0);
        query_pair(2, 2);
        query_pair(1, 1);
        query_pair(0, 3);
        query_pair(3, 0);
        query_pair(1, 2);
        query_pair(0, 1);
        write_table_size(2);
        load_entry(2, 8'd7, 8'd7, 8'd7, 16'd7);   // past the table: ignored
        load_entry(0, 8'd9, 8'd200, 8'd31, 16'd40000);
        load_entry(1, 8'd255, 8'd128, 8'd0, 16'hFFFF);
        query_pair(1, 1);
        query_pair(0, 1);
        query_pair(1, 0);
        query_pair(0, 2);                          // back index out of range
        query_pair(255, 0);                        // front index out of range

        // Full-depth build so every index bit is exercised.
        write_table_size(TSIZE_RESET);
        for (int k = 0; k < ENTRY_COUNT; k++) load_random(k);
        next_load = ENTRY_COUNT;
        query_pair(0, 255);
        query_pair(255, 0);
        query_pair(255, 255);
        random_phase(150);

        write_table_size(511);          // above the depth: limit stays at 256
        random_phase(160);
        write_table_size(37);
        calm = 1'b1;                    // no bubbles, no backpressure here
        random_phase(160);
        calm = 1'b0;
        write_table_size(300);
        random_phase(160);
        write_table_size(2);
        random_phase(120);
        write_table_size(129);
        random_phase(160);
        write_table_size(256);
        random_phase(160);

        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("preintegrated_transfer_table_core: match");
        else
            $display("preintegrated_transfer_table_core: mismatch");
        $finish;
    end
endmodule
